### hw/rtl/ae_pkg.sv
// Shared types and constants for the arithmetic encoder.
package ae_pkg;

    localparam int KIND_W        = 2;
    localparam int INDEX_W       = 5;
    localparam int TABLE_VALUE_W = 14;
    localparam int SYMBOL_W      = 5;
    localparam int BYTE_W        = 8;
    localparam int BITS_FREE_W   = 4;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [INDEX_W-1:0]       table_index;
        logic [TABLE_VALUE_W-1:0] table_value;
        logic [SYMBOL_W-1:0]      symbol;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              follow_overflow;
    } result_t;

    // Command from the sequencer to the bit packer
    typedef struct packed {
        logic push;
        logic flush;
        logic code_bit;
        logic flag;
    } pack_cmd_t;

endpackage

### hw/rtl/ae_table_mem.sv
// Cumulative frequency table: one write port, one registered read port.
module ae_table_mem #(
    parameter int DEPTH = 18,
    parameter int AW    = 5,
    parameter int DW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/ae_divider.sv
// Two-lane multiply then restoring divide: width*upper/total and width*lower/total.
module ae_divider #(
    parameter int CODE_BITS = 16,
    parameter int FREQ_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CODE_BITS:0]   width,
    input  logic [FREQ_BITS-1:0] upper,
    input  logic [FREQ_BITS-1:0] lower,
    input  logic [FREQ_BITS-1:0] total,
    output logic                 done,
    output logic [CODE_BITS:0]   q_hi,
    output logic [CODE_BITS:0]   q_lo
);
    import ae_pkg::*;

    localparam int QW   = CODE_BITS + 1;
    localparam int PW   = QW + FREQ_BITS;
    localparam int CNTW = $clog2(QW + 1);

    logic [PW-1:0]      acc_reg [2];
    logic [PW-1:0]      acc_next [2];
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [FREQ_BITS:0] trial [2];
    logic [FREQ_BITS:0] rem [2];
    logic               ge [2];

    // Quotient fits in QW bits since upper <= total, so the top FREQ_BITS of
    // the product already sit below total and only QW steps are needed.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            trial[i] = {acc_reg[i][PW-1:QW], acc_reg[i][CODE_BITS]};
            ge[i]    = trial[i] >= {1'b0, total};
            rem[i]   = ge[i] ? trial[i] - {1'b0, total} : trial[i];
            acc_next[i] = {rem[i][FREQ_BITS-1:0], acc_reg[i][CODE_BITS-1:0], ge[i]};
        end
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(QW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg[0] <= PW'(width) * PW'(upper);
            acc_reg[1] <= PW'(width) * PW'(lower);
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            acc_reg[0] <= acc_next[0];
            acc_reg[1] <= acc_next[1];
        end
    end

    assign done = busy_reg && cnt_reg == '0;
    assign q_hi = acc_reg[0][CODE_BITS:0];
    assign q_lo = acc_reg[1][CODE_BITS:0];

endmodule

### hw/rtl/ae_packer.sv
// Bit packer: shifts code bits into bytes, first bit in bit 0, and holds the output register.
module ae_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  ae_pkg::pack_cmd_t cmd,
    output logic              cmd_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output ae_pkg::result_t   result
);
    import ae_pkg::*;

    logic [BYTE_W-1:0]      buf_reg, buf_next;
    logic [BITS_FREE_W-1:0] bits_free_reg, bits_free_next;
    logic                   valid_reg, valid_next;
    result_t                res_reg, res_next;
    logic                   slot_free;
    logic                   byte_full;
    logic                   emit;
    logic [BYTE_W-1:0]      shifted;

    assign slot_free = !valid_reg || result_ready;
    assign byte_full = bits_free_reg == BITS_FREE_W'(1);
    assign shifted   = {cmd.code_bit, buf_reg[BYTE_W-1:1]};
    assign cmd_ready = slot_free || (cmd.push && !byte_full);

    always_comb
    begin
        buf_next       = buf_reg;
        bits_free_next = bits_free_reg;
        res_next       = res_reg;
        emit           = 1'b0;
        if (cmd.push && cmd_ready)
        begin
            buf_next = shifted;
            if (byte_full)
            begin
                emit           = 1'b1;
                res_next       = '{out_byte: shifted, last: 1'b0, follow_overflow: cmd.flag};
                bits_free_next = BITS_FREE_W'(BYTE_W);
            end
            else
            begin
                bits_free_next = bits_free_reg - BITS_FREE_W'(1);
            end
        end
        else if (cmd.flush && cmd_ready)
        begin
            // partial byte right-aligned; an empty one comes out as zero
            emit           = 1'b1;
            res_next       = '{out_byte: buf_reg >> bits_free_reg, last: 1'b1,
                               follow_overflow: cmd.flag};
            buf_next       = '0;
            bits_free_next = BITS_FREE_W'(BYTE_W);
        end
        valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            bits_free_reg <= BITS_FREE_W'(BYTE_W);
            valid_reg     <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            bits_free_reg <= bits_free_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

### hw/rtl/arithmetic_encoder.sv
// Top level of the static-model arithmetic encoder for symbols 1 to SYMBOLS.
//
//   channel | direction | handshake                   | payload
//   item    | in        | item_valid / item_ready     | ae_pkg::item_t
//   result  | out       | result_valid / result_ready | ae_pkg::result_t
//
// Load: a single table write. Encode: upper and lower table reads, an interval check, the
// iterative divide, then renormalisation steps, each emitted bit followed by its pending
// follow bits. Finish: one closing bit, its pending follow bits, then the final byte flush.
// The coder takes a new item only in the idle state, after the last one is through.
// Reset clears the coder; table entries are undefined until loaded.
// A full output register stalls the sequencer only when a byte completes or the stream closes.
module arithmetic_encoder #(
    parameter int CODE_BITS  = 16,
    parameter int SYMBOLS    = 17,
    parameter int FREQ_BITS  = 14,
    parameter int MAX_FOLLOW = 255
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  ae_pkg::item_t   item,
    output logic            result_valid,
    input  logic            result_ready,
    output ae_pkg::result_t result
);
    import ae_pkg::*;

    localparam int DEPTH = SYMBOLS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_FOLLOW + 1);
    localparam int WW    = CODE_BITS + 1;
    localparam int GW    = $clog2(CODE_BITS + 2);

    localparam logic [CODE_BITS-1:0] HALF  = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] QTR   = CODE_BITS'(1) << (CODE_BITS - 2);
    localparam logic [CODE_BITS-1:0] TQTR  = HALF | QTR;
    localparam logic [FW-1:0]        FOLLOW_MAX  = FW'(MAX_FOLLOW);
    localparam logic [GW-1:0]        GUARD_LIMIT = GW'(CODE_BITS + 1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_RD_UPPER = 9'b000000010,
        S_RD_LOWER = 9'b000000100,
        S_CHECK    = 9'b000001000,
        S_DIVIDE   = 9'b000010000,
        S_RENORM   = 9'b000100000,
        S_FOLLOW   = 9'b001000000,
        S_FIN_PUSH = 9'b010000000,
        S_FIN_BYTE = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CODE_BITS-1:0]   low_reg, low_next;
    logic [CODE_BITS-1:0]   high_reg, high_next;
    logic [FW-1:0]          pending_reg, pending_next;
    logic                   sat_reg, sat_next;
    logic [GW-1:0]          guard_reg, guard_next;
    logic                   fin_reg, fin_next;
    logic                   follow_bit_reg, follow_bit_next;
    logic [AW-1:0]          sym_reg, sym_next;
    logic [FREQ_BITS-1:0]   total_reg, total_next;
    logic [FREQ_BITS-1:0]   upper_reg, upper_next;
    logic [WW-1:0]          width_reg, width_next;

    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [FREQ_BITS-1:0]   mem_rdata;

    logic                   div_start, div_done;
    logic [WW-1:0]          q_hi, q_lo;
    logic [WW-1:0]          nhi, nlo, nhi_m1;

    pack_cmd_t              pk_cmd;
    logic                   pk_ready;

    logic                   idx_ok, sym_ok, interval_ok;
    logic                   below_half, above_half, middle;
    logic [CODE_BITS-1:0]   sub_val, low_sub, high_sub, low_sh, high_sh;
    logic                   fin_bit;

    assign item_ready = state_reg == S_IDLE;

    assign idx_ok = 32'(item.table_index) <= SYMBOLS;
    assign sym_ok = item.symbol != '0 && 32'(item.symbol) <= SYMBOLS;
    assign interval_ok = total_reg != '0 && mem_rdata < upper_reg && upper_reg <= total_reg;

    assign nhi    = {1'b0, low_reg} + q_hi;
    assign nlo    = {1'b0, low_reg} + q_lo;
    assign nhi_m1 = nhi - WW'(1);

    assign below_half = high_reg < HALF;
    assign above_half = low_reg >= HALF;
    assign middle     = low_reg >= QTR && high_reg < TQTR;
    // a lower-half step shifts only, even when the middle test also holds
    assign sub_val    = above_half ? HALF : ((middle && !below_half) ? QTR : '0);
    assign low_sub    = low_reg - sub_val;
    assign high_sub   = high_reg - sub_val;
    assign low_sh     = {low_sub[CODE_BITS-2:0], 1'b0};
    assign high_sh    = {high_sub[CODE_BITS-2:0], 1'b1};
    assign fin_bit    = low_reg >= QTR;

    // Table writes happen only at an accepted load and reads only for an encode item, so a
    // read never meets a write to the same entry.
    ae_table_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (FREQ_BITS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(item.table_index)),
        .wdata (item.table_value[FREQ_BITS-1:0]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ae_divider #(
        .CODE_BITS (CODE_BITS),
        .FREQ_BITS (FREQ_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .width (width_reg),
        .upper (upper_reg),
        .lower (mem_rdata),
        .total (total_reg),
        .done  (div_done),
        .q_hi  (q_hi),
        .q_lo  (q_lo)
    );

    ae_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pk_cmd),
        .cmd_ready    (pk_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        pending_next    = pending_reg;
        sat_next        = sat_reg;
        guard_next      = guard_reg;
        fin_next        = fin_reg;
        follow_bit_next = follow_bit_reg;
        sym_next        = sym_reg;
        total_next      = total_reg;
        upper_next      = upper_reg;
        width_next      = width_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        div_start       = 1'b0;
        pk_cmd          = '0;
        pk_cmd.flag     = sat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.kind)
                        KIND_LOAD:
                        begin
                            mem_we = idx_ok;
                        end
                        KIND_ENCODE:
                        begin
                            sat_next = 1'b0;
                            if (sym_ok)
                            begin
                                mem_re     = 1'b1;
                                sym_next   = AW'(item.symbol);
                                state_next = S_RD_UPPER;
                            end
                        end
                        KIND_FINISH:
                        begin
                            // closing step counts one more follow bit
                            if (pending_reg >= FOLLOW_MAX)
                            begin
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                sat_next     = 1'b0;
                                pending_next = pending_reg + FW'(1);
                            end
                            state_next = S_FIN_PUSH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_UPPER:
            begin
                total_next = mem_rdata;
                width_next = WW'(high_reg) - WW'(low_reg) + WW'(1);
                mem_re     = 1'b1;
                mem_raddr  = sym_reg - AW'(1);
                state_next = S_RD_LOWER;
            end
            S_RD_LOWER:
            begin
                upper_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = sym_reg;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (interval_ok)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVIDE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    if (nhi > nlo)
                    begin
                        high_next  = nhi_m1[CODE_BITS-1:0];
                        low_next   = nlo[CODE_BITS-1:0];
                        guard_next = '0;
                        state_next = S_RENORM;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RENORM:
            begin
                priority if (guard_reg == GUARD_LIMIT)
                begin
                    state_next = S_IDLE;
                end
                else if (below_half || above_half)
                begin
                    pk_cmd.push     = 1'b1;
                    pk_cmd.code_bit = above_half;
                    if (pk_ready)
                    begin
                        low_next        = low_sh;
                        high_next       = high_sh;
                        guard_next      = guard_reg + GW'(1);
                        follow_bit_next = !above_half;
                        fin_next        = 1'b0;
                        if (pending_reg != '0)
                        begin
                            state_next = S_FOLLOW;
                        end
                    end
                end
                else if (middle)
                begin
                    if (pending_reg >= FOLLOW_MAX)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        pending_next = pending_reg + FW'(1);
                    end
                    low_next   = low_sh;
                    high_next  = high_sh;
                    guard_next = guard_reg + GW'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FOLLOW:
            begin
                pk_cmd.push     = 1'b1;
                pk_cmd.code_bit = follow_bit_reg;
                if (pk_ready)
                begin
                    pending_next = pending_reg - FW'(1);
                    if (pending_reg == FW'(1))
                    begin
                        state_next = fin_reg ? S_FIN_BYTE : S_RENORM;
                    end
                end
            end
            S_FIN_PUSH:
            begin
                pk_cmd.push     = 1'b1;
                pk_cmd.code_bit = fin_bit;
                if (pk_ready)
                begin
                    follow_bit_next = !fin_bit;
                    fin_next        = 1'b1;
                    state_next      = (pending_reg != '0) ? S_FOLLOW : S_FIN_BYTE;
                end
            end
            S_FIN_BYTE:
            begin
                pk_cmd.flush = 1'b1;
                if (pk_ready)
                begin
                    low_next     = '0;
                    high_next    = '1;
                    pending_next = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            low_reg     <= '0;
            high_reg    <= '1;
            pending_reg <= '0;
            sat_reg     <= 1'b0;
            guard_reg   <= '0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            pending_reg <= pending_next;
            sat_reg     <= sat_next;
            guard_reg   <= guard_next;
            fin_reg     <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        follow_bit_reg <= follow_bit_next;
        sym_reg        <= sym_next;
        total_reg      <= total_next;
        upper_reg      <= upper_next;
        width_reg      <= width_next;
    end

endmodule

### hw/rtl/ae_checker.sv
// Port-level checks for the arithmetic encoder, bound to the top level.
module ae_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_ready,
    input ae_pkg::item_t   item,
    input logic            result_valid,
    input logic            result_ready,
    input ae_pkg::result_t result
);
    import ae_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transaction completed");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    // bytes are only produced while an item is being worked on
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result appeared with no item in progress");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.kind == KIND_FINISH |=> !item_ready)
        else $error("finish transaction did not occupy the coder");

    a_bad_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.kind == KIND_ENCODE && item.symbol == '0
        |=> item_ready)
        else $error("symbol zero was not ignored");

endmodule

bind arithmetic_encoder ae_checker u_ae_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
